### src/ordered_wait_queue_top_assert.svh
// Assertion macros for the ordered wait queue.
// No dependencies; included by the top level.
`ifndef ORDERED_WAIT_QUEUE_TOP_ASSERT_SVH
`define ORDERED_WAIT_QUEUE_TOP_ASSERT_SVH

// Clocked assertion, disabled during reset
`define OWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion, also checked during reset
`define OWQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/owq_pkg.sv
// Package for the ordered wait queue: entry layout, command, status and FSM codes.
// No dependencies.
package owq_pkg;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] pid;
    logic [15:0] ppid;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REM_HEAD = 3'd1,
    CMD_REM_PID  = 3'd2,
    CMD_REM_PPID = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_RESP
  } state_e;

endpackage

### src/ordered_wait_queue_top.sv
// Ordered wait queue top level: FSM around one synchronous entry memory.
// Depends on owq_pkg and ordered_wait_queue_top_assert.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | request   | in_valid_i / in_ready_o | command, entry key/pid/ppid, match_id
//  out     | response  | out_valid_o/out_ready_i | status, removed entry, occupancy, head
//  cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_data_i (ordered mode)
//
// One request at a time. The single read port of the entry memory sets the pace:
// every scan step and every shifted entry takes a read, then a use or write.
// Clear and refused inserts skip the scan and go straight to the head read and response.
// Reset clears control state only; entry memory contents stay undefined until written.
// A finished response waits in the output register; the next request may be taken then.
`include "ordered_wait_queue_top_assert.svh"

module ordered_wait_queue_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] entry_key_i,
  input  logic [15:0] entry_pid_i,
  input  logic [15:0] entry_ppid_i,
  input  logic [15:0] match_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_key_o,
  output logic [15:0] out_pid_o,
  output logic [15:0] out_ppid_o,
  output logic [5:0]  occupancy_o,
  output logic        head_valid_o,
  output logic [31:0] head_key_o,
  output logic [15:0] head_pid_o,
  output logic [15:0] head_ppid_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] DepthW = (CW+1)'(QUEUE_DEPTH);

  // Control and request registers
  owq_pkg::state_e  state_q, state_d;
  logic             mode_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [2:0]       cmd_q, cmd_d;
  owq_pkg::entry_t  new_q, new_d;
  logic [15:0]      match_q, match_d;
  owq_pkg::status_e stat_q, stat_d;
  owq_pkg::entry_t  rem_q, rem_d;

  // Output register
  logic             ovalid_q, ovalid_d;
  owq_pkg::status_e ostat_q, ostat_d;
  owq_pkg::entry_t  orem_q, orem_d;
  logic [5:0]       oocc_q, oocc_d;
  logic             ohv_q, ohv_d;
  owq_pkg::entry_t  ohead_q, ohead_d;

  // Entry memory
  owq_pkg::entry_t  mem_q [QUEUE_DEPTH];
  owq_pkg::entry_t  rdata_q;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  owq_pkg::entry_t  wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Helpers
  logic [CW:0] idx_p1, idx_p2, count_w;
  logic        is_insert, hit;
  assign idx_p1    = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2    = {1'b0, idx_q} + (CW+1)'(2);
  assign count_w   = {1'b0, count_q};
  assign is_insert = (cmd_q == owq_pkg::CMD_INSERT);
  always_comb begin
    case (cmd_q)
      owq_pkg::CMD_REM_HEAD: hit = 1'b1;
      owq_pkg::CMD_REM_PID:  hit = (rdata_q.pid == match_q);
      owq_pkg::CMD_REM_PPID: hit = (rdata_q.ppid == match_q);
      default:               hit = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == owq_pkg::S_IDLE);

  // Next state and datapath control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    new_d    = new_q;
    match_d  = match_q;
    stat_d   = stat_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    orem_d   = orem_q;
    oocc_d   = oocc_q;
    ohv_d    = ohv_q;
    ohead_d  = ohead_q;
    raddr    = '0;
    waddr    = idx_q[AW-1:0];
    we       = 1'b0;
    wdata    = rdata_q;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      owq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          new_d   = '{key: entry_key_i, pid: entry_pid_i, ppid: entry_ppid_i};
          match_d = match_id_i;
          stat_d  = owq_pkg::ST_DONE;
          rem_d   = '0;
          idx_d   = '0;
          state_d = owq_pkg::S_HEAD_RD;
          case (command_i)
            owq_pkg::CMD_INSERT: begin
              if (count_w == DepthW) begin
                stat_d = owq_pkg::ST_FULL;
              end else if (mode_q && count_q != '0) begin
                state_d = owq_pkg::S_SCAN_RD;
              end else begin
                pos_d   = count_q;
                idx_d   = count_q;
                state_d = owq_pkg::S_PUT;
              end
            end
            owq_pkg::CMD_REM_HEAD, owq_pkg::CMD_REM_PID, owq_pkg::CMD_REM_PPID: begin
              if (count_q == '0) begin
                stat_d = owq_pkg::ST_NONE;
              end else begin
                state_d = owq_pkg::S_SCAN_RD;
              end
            end
            owq_pkg::CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end

      owq_pkg::S_SCAN_RD: begin
        raddr   = idx_q[AW-1:0];
        state_d = owq_pkg::S_SCAN_CHK;
      end

      // Decide on the entry read at idx
      owq_pkg::S_SCAN_CHK: begin
        if (is_insert) begin
          if (rdata_q.key > new_q.key) begin
            pos_d   = idx_q;
            idx_d   = count_q;
            state_d = owq_pkg::S_SHIFT_RD;
          end else if (idx_p1 == count_w) begin
            pos_d   = count_q;
            idx_d   = count_q;
            state_d = owq_pkg::S_PUT;
          end else begin
            idx_d   = idx_p1[CW-1:0];
            state_d = owq_pkg::S_SCAN_RD;
          end
        end else if (hit) begin
          rem_d = rdata_q;
          pos_d = idx_q;
          if (idx_p1 < count_w) begin
            state_d = owq_pkg::S_SHIFT_RD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = owq_pkg::S_HEAD_RD;
          end
        end else if (idx_p1 == count_w) begin
          stat_d  = owq_pkg::ST_NONE;
          state_d = owq_pkg::S_HEAD_RD;
        end else begin
          idx_d   = idx_p1[CW-1:0];
          state_d = owq_pkg::S_SCAN_RD;
        end
      end

      // Insert moves entries up from the tail; remove pulls them down
      owq_pkg::S_SHIFT_RD: begin
        raddr   = is_insert ? AW'(idx_q - CW'(1)) : idx_p1[AW-1:0];
        state_d = owq_pkg::S_SHIFT_WR;
      end

      owq_pkg::S_SHIFT_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        if (is_insert) begin
          idx_d = idx_q - CW'(1);
          state_d = ((idx_q - CW'(1)) > pos_q) ? owq_pkg::S_SHIFT_RD : owq_pkg::S_PUT;
        end else begin
          idx_d = idx_p1[CW-1:0];
          if (idx_p2 < count_w) begin
            state_d = owq_pkg::S_SHIFT_RD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = owq_pkg::S_HEAD_RD;
          end
        end
      end

      owq_pkg::S_PUT: begin
        we      = 1'b1;
        waddr   = pos_q[AW-1:0];
        wdata   = new_q;
        count_d = count_q + CW'(1);
        state_d = owq_pkg::S_HEAD_RD;
      end

      owq_pkg::S_HEAD_RD: begin
        raddr   = '0;
        state_d = owq_pkg::S_HEAD_WAIT;
      end

      owq_pkg::S_HEAD_WAIT: begin
        raddr   = '0;
        state_d = owq_pkg::S_RESP;
      end

      // Load the output register once it is free
      owq_pkg::S_RESP: begin
        raddr = '0;
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = stat_q;
          orem_d   = rem_q;
          oocc_d   = 6'(count_q);
          ohv_d    = (count_q != '0);
          ohead_d  = (count_q != '0) ? rdata_q : '0;
          state_d  = owq_pkg::S_IDLE;
        end
      end

      default: state_d = owq_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= owq_pkg::S_IDLE;
      mode_q   <= 1'b0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    cmd_q   <= cmd_d;
    new_q   <= new_d;
    match_q <= match_d;
    stat_q  <= stat_d;
    rem_q   <= rem_d;
    ostat_q <= ostat_d;
    orem_q  <= orem_d;
    oocc_q  <= oocc_d;
    ohv_q   <= ohv_d;
    ohead_q <= ohead_d;
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign out_key_o    = orem_q.key;
  assign out_pid_o    = orem_q.pid;
  assign out_ppid_o   = orem_q.ppid;
  assign occupancy_o  = oocc_q;
  assign head_valid_o = ohv_q;
  assign head_key_o   = ohead_q.key;
  assign head_pid_o   = ohead_q.pid;
  assign head_ppid_o  = ohead_q.ppid;

  // Checks
  `OWQ_ASSERT(a_count_bound, count_w <= DepthW, "entry count above depth")
  `OWQ_ASSERT(a_write_busy, we |-> (state_q != owq_pkg::S_IDLE),
              "memory write while idle")
  `OWQ_ASSERT(a_full_occ,
              (out_valid_o && status_o == owq_pkg::ST_FULL) |->
              (occupancy_o == 6'(QUEUE_DEPTH)),
              "refused insert with room left")
  `OWQ_ASSERT_ALWAYS(a_shift_idx,
                     (state_q == owq_pkg::S_SHIFT_WR) |-> ({1'b0, idx_q} < DepthW),
                     "shift index out of range")

endmodule

### test/ordered_wait_queue_checker.sv
// Checker for the ordered wait queue: watches the config, request and response channels,
// keeps its own copy of the queue and compares every response. Depends on owq_pkg.
`timescale 1ns / 100ps

module ordered_wait_queue_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] entry_key_i,
  input  logic [15:0] entry_pid_i,
  input  logic [15:0] entry_ppid_i,
  input  logic [15:0] match_id_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] out_key_i,
  input  logic [15:0] out_pid_i,
  input  logic [15:0] out_ppid_i,
  input  logic [5:0]  occupancy_i,
  input  logic        head_valid_i,
  input  logic [31:0] head_key_i,
  input  logic [15:0] head_pid_i,
  input  logic [15:0] head_ppid_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    owq_pkg::status_e status;
    owq_pkg::entry_t  removed;
    logic [5:0]       occupancy;
    logic             head_valid;
    owq_pkg::entry_t  head;
  } resp_t;

  owq_pkg::entry_t queue_model[$];
  logic            ordered_q;
  resp_t           expected_resp_q[$];

  // Apply one request to the model queue and return the response it gives
  function automatic resp_t apply_request(logic [2:0] cmd, owq_pkg::entry_t ent,
                                          logic [15:0] match);
    resp_t r;
    int    pos;
    r = '0;
    r.status = owq_pkg::ST_DONE;
    case (cmd)
      owq_pkg::CMD_INSERT: begin
        if (queue_model.size() >= QUEUE_DEPTH) begin
          r.status = owq_pkg::ST_FULL;
        end else begin
          pos = queue_model.size();
          if (ordered_q) begin
            pos = 0;
            while (pos < queue_model.size() && queue_model[pos].key <= ent.key) pos++;
          end
          queue_model.insert(pos, ent);
        end
      end
      owq_pkg::CMD_REM_HEAD: begin
        if (queue_model.size() == 0) r.status = owq_pkg::ST_NONE;
        else r.removed = queue_model.pop_front();
      end
      owq_pkg::CMD_REM_PID, owq_pkg::CMD_REM_PPID: begin
        pos = -1;
        foreach (queue_model[i]) begin
          if (pos < 0 && ((cmd == owq_pkg::CMD_REM_PID) ? queue_model[i].pid :
              queue_model[i].ppid) == match) pos = i;
        end
        if (pos < 0) begin
          r.status = owq_pkg::ST_NONE;
        end else begin
          r.removed = queue_model[pos];
          queue_model.delete(pos);
        end
      end
      owq_pkg::CMD_CLEAR: queue_model.delete();
      default: ;
    endcase
    r.occupancy = 6'(queue_model.size());
    if (queue_model.size() > 0) begin
      r.head_valid = 1'b1;
      r.head = queue_model[0];
    end
    return r;
  endfunction

  // Track config, predict on accepted requests, compare accepted responses
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    resp_t exp_r;
    owq_pkg::entry_t ent;
    if (!rst_ni) begin
      ordered_q = 1'b0;
      queue_model.delete();
      expected_resp_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ordered_q = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        ent = '{key: entry_key_i, pid: entry_pid_i, ppid: entry_ppid_i};
        expected_resp_q.push_back(apply_request(command_i, ent, match_id_i));
      end
      if (out_valid_i && out_ready_i) begin
        got.status = owq_pkg::status_e'(status_i);
        got.removed = '{key: out_key_i, pid: out_pid_i, ppid: out_ppid_i};
        got.occupancy = occupancy_i;
        got.head_valid = head_valid_i;
        got.head = '{key: head_key_i, pid: head_pid_i, ppid: head_ppid_i};
        if (expected_resp_q.size() == 0) begin
          $display("%0t: unexpected response, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_resp_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected st=%0d rm=%h occ=%0d hv=%b hd=%h", $time,
                     exp_r.status, exp_r.removed, exp_r.occupancy, exp_r.head_valid,
                     exp_r.head);
            $display("%0t:          actual   st=%0d rm=%h occ=%0d hv=%b hd=%h", $time,
                     got.status, got.removed, got.occupancy, got.head_valid, got.head);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_resp_q.size();
    end
  end

endmodule

### test/ordered_wait_queue_top_tb.sv
// Testbench top for the ordered wait queue: drives config and requests, throttles the
// response side, gives the verdict. Depends on owq_pkg, the DUT and the checker.
`timescale 1ns / 100ps

module ordered_wait_queue_top_tb;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [31:0] entry_key_i = '0;
  logic [15:0] entry_pid_i = '0;
  logic [15:0] entry_ppid_i = '0;
  logic [15:0] match_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] out_key_o;
  logic [15:0] out_pid_o;
  logic [15:0] out_ppid_o;
  logic [5:0]  occupancy_o;
  logic        head_valid_o;
  logic [31:0] head_key_o;
  logic [15:0] head_pid_o;
  logic [15:0] head_ppid_o;

  int fail_count;
  int pending_resp;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;
  logic [15:0] recent_pid[$];

  always #5 clk_i = ~clk_i;

  ordered_wait_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  ordered_wait_queue_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .cfg_ready_i(cfg_ready_o), .in_ready_i(in_ready_o), .out_valid_i(out_valid_o),
    .status_i(status_o), .out_key_i(out_key_o), .out_pid_i(out_pid_o),
    .out_ppid_i(out_ppid_o), .occupancy_i(occupancy_o), .head_valid_i(head_valid_o),
    .head_key_i(head_key_o), .head_pid_i(head_pid_o), .head_ppid_i(head_ppid_o),
    .fail_count_o(fail_count), .pending_o(pending_resp), .*);

  // Response side throttling
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one request, with optional random gap before it; valid stays up until the next
  // gap or drain
  task automatic send_request(logic [2:0] cmd, logic [31:0] key, logic [15:0] pid,
                              logic [15:0] ppid, logic [15:0] match);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    entry_key_i <= key;
    entry_pid_i <= pid;
    entry_ppid_i <= ppid;
    match_id_i <= match;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd == owq_pkg::CMD_INSERT) begin
      recent_pid.push_back(pid);
      if (recent_pid.size() > 40) void'(recent_pid.pop_front());
    end
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_resp != 0) @(posedge clk_i);
    repeat (4 * DEPTH + 20) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    drain_all();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random request, mostly inserts and removals that hit stored ids
  task automatic random_request();
    int sel;
    logic [15:0] m;
    logic [31:0] key;
    sel = $urandom_range(99);
    m = (recent_pid.size() > 0 && $urandom_range(3) != 0) ?
        recent_pid[$urandom_range(recent_pid.size() - 1)] : 16'($urandom);
    key = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
    if (sel < 48) send_request(owq_pkg::CMD_INSERT, key, 16'($urandom),
                               16'($urandom_range(7)), 16'($urandom));
    else if (sel < 66) send_request(owq_pkg::CMD_REM_HEAD, $urandom, 16'($urandom),
                                    16'($urandom), m);
    else if (sel < 82) send_request(owq_pkg::CMD_REM_PID, $urandom, 16'($urandom),
                                    16'($urandom), m);
    else if (sel < 94) send_request(owq_pkg::CMD_REM_PPID, $urandom, 16'($urandom),
                                    16'($urandom), 16'($urandom_range(7)));
    else if (sel < 97) send_request(owq_pkg::CMD_CLEAR, $urandom, 16'($urandom),
                                    16'($urandom), m);
    else send_request(3'($urandom_range(7, 5)), $urandom, 16'($urandom), 16'($urandom), m);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty removals, extremes, stable equal keys, full queue, unused codes
    send_request(owq_pkg::CMD_REM_HEAD, '0, '0, '0, '0);
    send_request(owq_pkg::CMD_REM_PID, '0, '0, '0, 16'hffff);
    send_request(owq_pkg::CMD_REM_PPID, '0, '0, '0, '0);
    send_request(owq_pkg::CMD_INSERT, 32'hffff_ffff, 16'hffff, 16'hffff, '0);
    send_request(owq_pkg::CMD_INSERT, '0, '0, '0, 16'hffff);
    send_request(owq_pkg::CMD_REM_PPID, '0, '0, '0, 16'hffff);
    send_request(owq_pkg::CMD_REM_PID, '0, '0, '0, 16'h1234);
    send_request(3'd7, '1, '1, '1, '1);
    send_request(owq_pkg::CMD_CLEAR, '0, '0, '0, '0);
    write_mode(1'b1);
    send_request(owq_pkg::CMD_INSERT, 32'd5, 16'd1, 16'd9, '0);
    send_request(owq_pkg::CMD_INSERT, 32'd5, 16'd2, 16'd9, '0);
    send_request(owq_pkg::CMD_INSERT, 32'd3, 16'd3, 16'd9, '0);
    send_request(owq_pkg::CMD_INSERT, 32'hffff_ffff, 16'd4, 16'd8, '0);
    send_request(owq_pkg::CMD_REM_PPID, '0, '0, '0, 16'd9);
    send_request(owq_pkg::CMD_REM_HEAD, '0, '0, '0, '0);
    // Fill past full with the receiver held off
    recv_hold = 1'b1;
    fork
      begin
        for (int i = 0; i < DEPTH + 2; i++)
          send_request(owq_pkg::CMD_INSERT, $urandom, 16'(i + 100), 16'(i), '0);
      end
      begin
        repeat (600) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join
    write_mode(1'b0);
    send_request(owq_pkg::CMD_INSERT, 32'd1, 16'd7, 16'd7, '0);
    send_request(3'd5, '0, '0, '0, '0);
    send_request(owq_pkg::CMD_CLEAR, '0, '0, '0, '0);

    // Random phases: mode and idling vary
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0] ^ ph[2]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 115; n++) begin
        random_request();
        if (n == 60 && ph == 3) drain_all();
      end
    end

    drain_all();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/owq_pkg.sv
src/ordered_wait_queue_top.sv
test/ordered_wait_queue_checker.sv
test/ordered_wait_queue_top_tb.sv
